// ===== hdl/slx_pkg.sv =====
// shared types, token codes and character helpers for the script lexer
// no dependencies

package slx_pkg;

    localparam int NEST_DEPTH_DEF = 16;
    localparam int FQ_DEPTH       = 4;

    // token codes
    localparam logic [5:0] TK_PLUS      = 6'd1;
    localparam logic [5:0] TK_MINUS     = 6'd2;
    localparam logic [5:0] TK_STAR      = 6'd3;
    localparam logic [5:0] TK_SLASH     = 6'd4;
    localparam logic [5:0] TK_PLUS_EQ   = 6'd5;
    localparam logic [5:0] TK_MINUS_EQ  = 6'd6;
    localparam logic [5:0] TK_STAR_EQ   = 6'd7;
    localparam logic [5:0] TK_SLASH_EQ  = 6'd8;
    localparam logic [5:0] TK_ASSIGN    = 6'd11;
    localparam logic [5:0] TK_EQ        = 6'd12;
    localparam logic [5:0] TK_EQQ       = 6'd13;
    localparam logic [5:0] TK_NE        = 6'd14;
    localparam logic [5:0] TK_QUEST     = 6'd15;
    localparam logic [5:0] TK_DOT       = 6'd16;
    localparam logic [5:0] TK_COMMA     = 6'd17;
    localparam logic [5:0] TK_COLON     = 6'd18;
    localparam logic [5:0] TK_DCOLON    = 6'd19;
    localparam logic [5:0] TK_SEMI      = 6'd20;
    localparam logic [5:0] TK_AMP       = 6'd21;
    localparam logic [5:0] TK_LPAREN    = 6'd22;
    localparam logic [5:0] TK_RPAREN    = 6'd23;
    localparam logic [5:0] TK_LBRACK    = 6'd24;
    localparam logic [5:0] TK_RBRACK    = 6'd25;
    localparam logic [5:0] TK_LBRACE    = 6'd26;
    localparam logic [5:0] TK_RBRACE    = 6'd27;
    localparam logic [5:0] TK_BAR       = 6'd28;
    localparam logic [5:0] TK_ANDAND    = 6'd29;
    localparam logic [5:0] TK_OROR      = 6'd30;
    localparam logic [5:0] TK_BANG      = 6'd31;
    localparam logic [5:0] TK_EOF       = 6'd32;
    localparam logic [5:0] TK_STR_INT   = 6'd33;
    localparam logic [5:0] TK_CSTR_INT  = 6'd34;
    localparam logic [5:0] TK_STR       = 6'd35;
    localparam logic [5:0] TK_CSTR      = 6'd36;
    localparam logic [5:0] TK_NUMBER    = 6'd37;
    localparam logic [5:0] TK_IVAR      = 6'd38;
    localparam logic [5:0] TK_IDENT     = 6'd39;
    localparam logic [5:0] TK_IDENT_SFX = 6'd40;
    localparam logic [5:0] TK_KW_FIRST  = 6'd42;
    localparam logic [5:0] TK_NONE      = 6'd0;

    localparam int KW_COUNT = 20;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'("if"), 48'("unless"), 48'("else"), 48'("elsif"), 48'("then"),
        48'("when"), 48'("case"), 48'("class"), 48'("module"), 48'("def"),
        48'("self"), 48'("do"), 48'("yield"), 48'("true"), 48'("false"),
        48'("nil"), 48'("not"), 48'("and"), 48'("or"), 48'("end")
    };

    // one result beat
    typedef struct packed {
        logic        item_kind;
        logic [5:0]  token_code;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic        space_before;
        logic [7:0]  content_byte;
        logic        last_of_run;
        logic        nest_overflow;
    } t_result;

    // results of one source byte, front to queue
    typedef struct packed {
        logic [1:0]    count;
        t_result [1:0] res;
    } t_front_out;

    function automatic logic is_space(input logic [7:0] b);
        return b != 8'h10 && b != 8'h13 && b >= 8'd1 && b <= 8'd32;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || is_digit(b) || b == "_";
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // identifier or keyword code
    function automatic logic [5:0] kw_code(input logic [47:0] kw, input logic [15:0] len,
                                           input logic nk);
        logic [5:0] code;
        code = TK_IDENT;
        if (!nk && len <= 16'd6) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (KW_TEXT[i] == kw) code = TK_KW_FIRST + 6'(i);
            end
        end
        return code;
    endfunction

    function automatic t_result mk_res(input logic kind, input logic [5:0] code,
                                       input logic [31:0] start, input logic [15:0] len,
                                       input logic sp, input logic [7:0] cb,
                                       input logic ovf);
        t_result r;
        r.item_kind     = kind;
        r.token_code    = code;
        r.start_offset  = start;
        r.token_length  = len;
        r.space_before  = sp;
        r.content_byte  = cb;
        r.last_of_run   = 1'b0;
        r.nest_overflow = ovf;
        return r;
    endfunction

endpackage

// ===== hdl/slx_if.sv =====
// channel interfaces for the script lexer: source bytes in, results out
// no dependencies

interface slx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       no_keywords;
    modport source(output valid, source_byte, no_keywords, input ready);
    modport sink(input valid, source_byte, no_keywords, output ready);
endinterface

interface slx_res_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [5:0]  token_code;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        space_before;
    logic [7:0]  content_byte;
    logic        last_of_run;
    logic        nest_overflow;
    modport source(output valid, item_kind, token_code, start_offset, token_length,
                   space_before, content_byte, last_of_run, nest_overflow, input ready);
    modport sink(input valid, item_kind, token_code, start_offset, token_length,
                 space_before, content_byte, last_of_run, nest_overflow, output ready);
endinterface

// ===== hdl/slx_front.sv =====
// lexer front: scan state, brace stack, up to two results per source byte
// depends on slx_pkg

module slx_front import slx_pkg::*; #(
    parameter int NEST_DEPTH = NEST_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_nk,
    output t_front_out o_out
);
    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int CW = $clog2(NEST_DEPTH + 1);

    localparam logic [4:0] M_IDLE = 5'd0,  M_PLUS = 5'd1,  M_MINUS = 5'd2,
                           M_STAR = 5'd3,  M_SLASH = 5'd4, M_EQ1 = 5'd5,
                           M_EQ2 = 5'd6,   M_BANG = 5'd7,  M_COLON = 5'd8,
                           M_BAR = 5'd9,   M_AMP = 5'd10,  M_AT = 5'd11,
                           M_IVAR = 5'd12, M_NUM = 5'd13,  M_IDENT = 5'd14,
                           M_SQ = 5'd15,   M_SQ_ESC = 5'd16, M_SQ_LIT = 5'd17,
                           M_DQ = 5'd18,   M_DQ_HASH = 5'd19, M_DQC = 5'd20,
                           M_DQC_HASH = 5'd21;

    logic [4:0]    r_mode, n_mode;
    logic [47:0]   r_kw, n_kw;
    logic [15:0]   r_wlen, n_wlen;
    logic [31:0]   r_tstart, n_tstart;
    logic [31:0]   r_off, n_off;
    logic          r_sp, n_sp;
    logic [CW-1:0] r_count, n_count;
    logic          r_top, n_top;
    logic          r_below;
    logic          stack_mem [NEST_DEPTH];
    logic          push, push_kind, pop;
    t_result [1:0] res;
    logic [1:0]    cnt;

    // next state and results for one byte
    always_comb begin
        logic       do_idle, pair, ovf, full;
        logic [7:0] pc;
        logic [5:0] cc, sc, single;
        logic [31:0] off;
        n_mode = r_mode; n_kw = r_kw; n_wlen = r_wlen; n_tstart = r_tstart;
        n_sp = r_sp; n_count = r_count; n_top = r_top;
        off = r_off;
        n_off = r_off + 32'd1;
        push = 1'b0; push_kind = 1'b0; pop = 1'b0;
        res = '0; cnt = 2'd0;
        do_idle = 1'b0; pair = 1'b0; ovf = 1'b0; single = TK_NONE;
        pc = 8'd0; cc = TK_NONE; sc = TK_NONE;
        full = r_count >= CW'(NEST_DEPTH);

        // simple operators with one compound form
        case (r_mode)
            M_PLUS:  begin pair = 1'b1; pc = "="; cc = TK_PLUS_EQ;  sc = TK_PLUS;  end
            M_MINUS: begin pair = 1'b1; pc = "="; cc = TK_MINUS_EQ; sc = TK_MINUS; end
            M_STAR:  begin pair = 1'b1; pc = "="; cc = TK_STAR_EQ;  sc = TK_STAR;  end
            M_SLASH: begin pair = 1'b1; pc = "="; cc = TK_SLASH_EQ; sc = TK_SLASH; end
            M_BANG:  begin pair = 1'b1; pc = "="; cc = TK_NE;       sc = TK_BANG;  end
            M_COLON: begin pair = 1'b1; pc = ":"; cc = TK_DCOLON;   sc = TK_COLON; end
            M_BAR:   begin pair = 1'b1; pc = "|"; cc = TK_OROR;     sc = TK_BAR;   end
            M_AMP:   begin pair = 1'b1; pc = "&"; cc = TK_ANDAND;   sc = TK_AMP;   end
            default: pair = 1'b0;
        endcase

        if (pair) begin
            if (i_byte == pc) begin
                res[cnt] = mk_res(1'b0, cc, r_tstart, 16'd2, n_sp, 8'd0, 1'b0);
                cnt = cnt + 2'd1; n_sp = 1'b0; n_mode = M_IDLE;
            end else begin
                res[cnt] = mk_res(1'b0, sc, r_tstart, 16'd1, n_sp, 8'd0, 1'b0);
                cnt = cnt + 2'd1; n_sp = 1'b0; do_idle = 1'b1;
            end
        end else begin
            case (r_mode)
                M_EQ1: begin
                    if (i_byte == "=") begin
                        n_mode = M_EQ2; n_wlen = 16'd2;
                    end else begin
                        res[cnt] = mk_res(1'b0, TK_ASSIGN, r_tstart, 16'd1, n_sp, 8'd0, 1'b0);
                        cnt = cnt + 2'd1; n_sp = 1'b0; do_idle = 1'b1;
                    end
                end
                M_EQ2: begin
                    if (i_byte == "=") begin
                        res[cnt] = mk_res(1'b0, TK_EQQ, r_tstart, 16'd3, n_sp, 8'd0, 1'b0);
                        cnt = cnt + 2'd1; n_sp = 1'b0; n_mode = M_IDLE;
                    end else begin
                        res[cnt] = mk_res(1'b0, TK_EQ, r_tstart, 16'd2, n_sp, 8'd0, 1'b0);
                        cnt = cnt + 2'd1; n_sp = 1'b0; do_idle = 1'b1;
                    end
                end
                M_AT: begin
                    if (is_word(i_byte)) begin
                        n_mode = M_IVAR; n_wlen = 16'd2;
                    end else begin
                        n_sp = 1'b0; do_idle = 1'b1;
                    end
                end
                M_IVAR, M_NUM: begin
                    if ((r_mode == M_IVAR) ? is_word(i_byte) : is_digit(i_byte)) begin
                        n_wlen = sat_inc(r_wlen);
                    end else begin
                        res[cnt] = mk_res(1'b0, (r_mode == M_IVAR) ? TK_IVAR : TK_NUMBER,
                                          r_tstart, r_wlen, n_sp, 8'd0, 1'b0);
                        cnt = cnt + 2'd1; n_sp = 1'b0; do_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word(i_byte)) begin
                        if (r_wlen < 16'd6) n_kw = {r_kw[39:0], i_byte};
                        n_wlen = sat_inc(r_wlen);
                    end else if (i_byte == "?" || i_byte == "!") begin
                        res[cnt] = mk_res(1'b0, TK_IDENT_SFX, r_tstart, sat_inc(r_wlen),
                                          n_sp, 8'd0, 1'b0);
                        cnt = cnt + 2'd1; n_sp = 1'b0; n_mode = M_IDLE;
                    end else begin
                        res[cnt] = mk_res(1'b0, kw_code(r_kw, r_wlen, i_nk), r_tstart,
                                          r_wlen, n_sp, 8'd0, 1'b0);
                        cnt = cnt + 2'd1; n_sp = 1'b0; do_idle = 1'b1;
                    end
                end
                M_SQ, M_SQ_ESC, M_SQ_LIT, M_DQ, M_DQC, M_DQ_HASH, M_DQC_HASH: begin
                    if (i_byte == 8'd0) begin
                        // input ends inside a string: drop it, report end of file
                        res[cnt] = mk_res(1'b0, TK_EOF, off, 16'd0, 1'b0, 8'd0, 1'b0);
                        cnt = cnt + 2'd1; n_sp = 1'b0; n_mode = M_IDLE;
                    end else begin
                        case (r_mode)
                            M_SQ: begin
                                if (i_byte == "'") begin
                                    res[cnt] = mk_res(1'b0, TK_STR, r_tstart, r_wlen, n_sp,
                                                      8'd0, 1'b0);
                                    cnt = cnt + 2'd1; n_sp = 1'b0; n_mode = M_IDLE;
                                end else if (i_byte == "\\") begin
                                    n_mode = M_SQ_ESC;
                                end else begin
                                    res[cnt] = mk_res(1'b1, TK_NONE, r_tstart, 16'd0, 1'b0,
                                                      i_byte, 1'b0);
                                    cnt = cnt + 2'd1; n_wlen = sat_inc(n_wlen);
                                end
                            end
                            M_SQ_ESC: begin
                                if (i_byte == "\\" || i_byte == "'") begin
                                    n_mode = M_SQ_LIT;
                                end else begin
                                    res[cnt] = mk_res(1'b1, TK_NONE, r_tstart, 16'd0, 1'b0,
                                                      "\\", 1'b0);
                                    cnt = cnt + 2'd1; n_wlen = sat_inc(n_wlen);
                                    n_mode = M_SQ;
                                end
                                res[cnt] = mk_res(1'b1, TK_NONE, r_tstart, 16'd0, 1'b0,
                                                  i_byte, 1'b0);
                                cnt = cnt + 2'd1; n_wlen = sat_inc(n_wlen);
                            end
                            M_SQ_LIT: begin
                                res[cnt] = mk_res(1'b1, TK_NONE, r_tstart, 16'd0, 1'b0,
                                                  i_byte, 1'b0);
                                cnt = cnt + 2'd1; n_wlen = sat_inc(n_wlen);
                                n_mode = M_SQ;
                            end
                            M_DQ, M_DQC: begin
                                if (i_byte == "\"") begin
                                    res[cnt] = mk_res(1'b0, (r_mode == M_DQC) ? TK_CSTR : TK_STR,
                                                      r_tstart, r_wlen, n_sp, 8'd0, 1'b0);
                                    cnt = cnt + 2'd1; n_sp = 1'b0; n_mode = M_IDLE;
                                end else if (i_byte == "#") begin
                                    n_mode = (r_mode == M_DQC) ? M_DQC_HASH : M_DQ_HASH;
                                end else begin
                                    res[cnt] = mk_res(1'b1, TK_NONE, r_tstart, 16'd0, 1'b0,
                                                      i_byte, 1'b0);
                                    cnt = cnt + 2'd1; n_wlen = sat_inc(n_wlen);
                                end
                            end
                            default: begin
                                // after a hash in a double-quoted string
                                if (i_byte == "{") begin
                                    push = ~full; push_kind = 1'b1; ovf = full;
                                    res[cnt] = mk_res(1'b0,
                                        (r_mode == M_DQC_HASH) ? TK_CSTR_INT : TK_STR_INT,
                                        r_tstart, r_wlen, n_sp, 8'd0, ovf);
                                    cnt = cnt + 2'd1; n_sp = 1'b0; n_mode = M_IDLE;
                                end else begin
                                    res[cnt] = mk_res(1'b1, TK_NONE, r_tstart, 16'd0, 1'b0,
                                                      "#", 1'b0);
                                    cnt = cnt + 2'd1;
                                    res[cnt] = mk_res(1'b1, TK_NONE, r_tstart, 16'd0, 1'b0,
                                                      i_byte, 1'b0);
                                    cnt = cnt + 2'd1; n_wlen = sat_inc(sat_inc(r_wlen));
                                    n_mode = (r_mode == M_DQC_HASH) ? M_DQC : M_DQ;
                                end
                            end
                        endcase
                    end
                end
                default: do_idle = 1'b1;
            endcase
        end

        // lex the byte from the idle state
        if (do_idle) begin
            n_mode = M_IDLE;
            if (is_space(i_byte)) begin
                n_sp = 1'b1;
            end else begin
                case (i_byte)
                    8'd0: single = TK_EOF;
                    "(":  single = TK_LPAREN;
                    ")":  single = TK_RPAREN;
                    "?":  single = TK_QUEST;
                    ".":  single = TK_DOT;
                    ",":  single = TK_COMMA;
                    ";":  single = TK_SEMI;
                    "[":  single = TK_LBRACK;
                    "]":  single = TK_RBRACK;
                    "{": begin
                        push = ~full; push_kind = 1'b0; ovf = full;
                        single = TK_LBRACE;
                    end
                    "}": begin
                        if (r_count != '0) begin
                            pop = 1'b1;
                            if (r_top) begin
                                n_mode = M_DQC; n_tstart = off + 32'd1; n_wlen = 16'd0;
                            end else begin
                                single = TK_RBRACE;
                            end
                        end else begin
                            single = TK_RBRACE;
                        end
                    end
                    "\"": begin n_mode = M_DQ; n_tstart = off + 32'd1; n_wlen = 16'd0; end
                    "'":  begin n_mode = M_SQ; n_tstart = off + 32'd1; n_wlen = 16'd0; end
                    "+":  begin n_mode = M_PLUS;  n_tstart = off; n_wlen = 16'd1; end
                    "-":  begin n_mode = M_MINUS; n_tstart = off; n_wlen = 16'd1; end
                    "*":  begin n_mode = M_STAR;  n_tstart = off; n_wlen = 16'd1; end
                    "/":  begin n_mode = M_SLASH; n_tstart = off; n_wlen = 16'd1; end
                    "=":  begin n_mode = M_EQ1;   n_tstart = off; n_wlen = 16'd1; end
                    "!":  begin n_mode = M_BANG;  n_tstart = off; n_wlen = 16'd1; end
                    ":":  begin n_mode = M_COLON; n_tstart = off; n_wlen = 16'd1; end
                    "|":  begin n_mode = M_BAR;   n_tstart = off; n_wlen = 16'd1; end
                    "&":  begin n_mode = M_AMP;   n_tstart = off; n_wlen = 16'd1; end
                    "@":  begin n_mode = M_AT;    n_tstart = off; n_wlen = 16'd1; end
                    default: begin
                        if (is_digit(i_byte)) begin
                            n_mode = M_NUM; n_tstart = off; n_wlen = 16'd1;
                        end else if (is_word(i_byte)) begin
                            n_mode = M_IDENT; n_tstart = off; n_wlen = 16'd1;
                            n_kw = {40'd0, i_byte};
                        end else begin
                            n_sp = 1'b0;
                        end
                    end
                endcase
                if (single != TK_NONE) begin
                    res[cnt] = mk_res(1'b0, single, off, (i_byte == 8'd0) ? 16'd0 : 16'd1,
                                      n_sp, 8'd0, ovf);
                    cnt = cnt + 2'd1; n_sp = 1'b0;
                end
            end
        end

        // mark the last result of this byte
        if (cnt == 2'd1) res[0].last_of_run = 1'b1;
        if (cnt == 2'd2) res[1].last_of_run = 1'b1;

        // brace stack depth and cached top
        if (push) begin
            n_count = r_count + CW'(1);
            n_top = push_kind;
        end else if (pop) begin
            n_count = r_count - CW'(1);
            n_top = r_below;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_kw <= '0;
            r_wlen <= '0;
            r_tstart <= '0;
            r_off <= '0;
            r_sp <= 1'b0;
            r_count <= '0;
            r_top <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_kw <= n_kw;
            r_wlen <= n_wlen;
            r_tstart <= n_tstart;
            r_off <= n_off;
            r_sp <= n_sp;
            r_count <= n_count;
            r_top <= n_top;
        end
    end

    // brace stack memory, entry below the top read ahead
    always_ff @(posedge i_clk) begin
        if (i_fire && push) stack_mem[r_count[AW-1:0]] <= push_kind;
        if (i_fire) r_below <= stack_mem[AW'(n_count - CW'(2))];
        else        r_below <= stack_mem[AW'(r_count - CW'(2))];
    end

    assign o_out.count = i_fire ? cnt : 2'd0;
    assign o_out.res   = res;

endmodule

// ===== hdl/slx_fifo.sv =====
// result queue: takes up to two beats a cycle, gives one
// depends on slx_pkg

module slx_fifo import slx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_front_out i_wr,
    input  logic       i_pop,
    output logic       o_room,
    output logic       o_nonempty,
    output t_result    o_head
);
    localparam int PW = $clog2(FQ_DEPTH);

    t_result     r_mem [FQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          do_pop;

    assign do_pop     = i_pop && (r_cnt != '0);
    assign o_nonempty = r_cnt != '0;
    assign o_room     = r_cnt <= (PW + 1)'(FQ_DEPTH - 2);
    assign o_head     = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr.count != 2'd0) r_mem[r_wp] <= i_wr.res[0];
        if (i_wr.count == 2'd2) r_mem[r_wp + PW'(1)] <= i_wr.res[1];
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= r_wp + PW'(i_wr.count);
            if (do_pop) r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + (PW + 1)'(i_wr.count) - (PW + 1)'(do_pop);
        end
    end

endmodule

// ===== hdl/slx_back.sv =====
// output stage: holds one result beat for the receiver
// depends on slx_pkg

module slx_back import slx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_avail,
    input  t_result i_head,
    input  logic    i_ready,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_res
);
    logic    r_valid;
    t_result r_res;

    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // load a new beat when empty or when the held one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= i_head;
    end

endmodule

// ===== hdl/script_lexer_byte_stream.sv =====
// Byte-stream lexer for a small scripting language.
// Channels: i_src carries one source byte (plus the no_keywords flag) per beat;
// o_res carries one result per beat, either a token record or a decoded
// string content byte. A source byte yields zero, one or two results; the
// last result of a byte has last_of_run set. Byte zero ends the input.
// Throughput: one source byte per cycle while the receiver keeps up; results
// leave at one per cycle from the output register, so bytes that give two
// results fill the four-entry result queue and the source is held when fewer
// than two queue slots are free.
// Path: a result passes through the result queue and the output register to o_res.
// Tokens that need lookahead appear with the byte that ends them.
// Reset (synchronous, active low) returns the scanner to idle, offset zero,
// empty brace stack and empty queue; no clearing pass is needed.
// When the receiver stalls, the held result stays on o_res, the queue fills
// and i_src.ready drops until space returns.
// depends on slx_pkg, slx_if, slx_front, slx_fifo, slx_back

module script_lexer_byte_stream import slx_pkg::*; #(
    parameter int NEST_DEPTH = NEST_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    slx_byte_if.sink          i_src,
    slx_res_if.source         o_res
);
    t_front_out front_out;
    t_result    head, out_res;
    logic       room, nonempty, pop, fire;

    assign i_src.ready = room;
    assign fire = i_src.valid && room;

    slx_front #(.NEST_DEPTH(NEST_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (i_src.source_byte),
        .i_nk    (i_src.no_keywords),
        .o_out   (front_out)
    );

    slx_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (front_out),
        .i_pop      (pop),
        .o_room     (room),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    slx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (nonempty),
        .i_head  (head),
        .i_ready (o_res.ready),
        .o_pop   (pop),
        .o_valid (o_res.valid),
        .o_res   (out_res)
    );

    // result beat onto the port
    assign o_res.item_kind     = out_res.item_kind;
    assign o_res.token_code    = out_res.token_code;
    assign o_res.start_offset  = out_res.start_offset;
    assign o_res.token_length  = out_res.token_length;
    assign o_res.space_before  = out_res.space_before;
    assign o_res.content_byte  = out_res.content_byte;
    assign o_res.last_of_run   = out_res.last_of_run;
    assign o_res.nest_overflow = out_res.nest_overflow;

endmodule
